[rtl/pls_pkg.sv]
`default_nettype none

package pls_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int INDEX_W = 8;
  localparam int INDEX_COUNT = 1 << INDEX_W;
  localparam int SLOT_W = $clog2(PALETTE_DEPTH);
  localparam int COLOUR_W = 24;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CNT_W = $clog2(BITS_PER_PIXEL);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_PIXEL - 1);
  localparam int USER_ENTRY_BIT = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int HIGH_W = 10;
  localparam int PERIOD_W = 11;
  localparam int SHIFT_W = 4;

  localparam logic [SHIFT_W-1:0] RESET_DIM_SHIFT = '0;
  localparam logic [HIGH_W-1:0] RESET_ZERO_HIGH = HIGH_W'(18);
  localparam logic [HIGH_W-1:0] RESET_ONE_HIGH = HIGH_W'(45);
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(62);

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_DIM_ENABLE = 3'd0,
    REG_DIM_SHIFT  = 3'd1,
    REG_ZERO_HIGH  = 3'd2,
    REG_ONE_HIGH   = 3'd3,
    REG_PERIOD     = 3'd4
  } reg_index_t;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t slot_table_t [INDEX_COUNT];

  typedef struct packed {
    logic                dim_enable;
    logic [SHIFT_W-1:0]  dim_shift;
    logic [HIGH_W-1:0]   zero_high_ticks;
    logic [HIGH_W-1:0]   one_high_ticks;
    logic [PERIOD_W-1:0] bit_period_ticks;
  } pls_cfg_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] word;
    logic                frame_end;
  } pls_pixel_t;

  function automatic slot_table_t build_slot_table();
    slot_table_t t;
    for (int i = 0; i < INDEX_COUNT; i++) begin
      t[i] = SLOT_W'(i % PALETTE_DEPTH);
    end
    return t;
  endfunction

  localparam slot_table_t SLOT_TABLE = build_slot_table();

endpackage

`default_nettype wire

[rtl/pls_in_if.sv]
`default_nettype none

interface pls_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [pls_pkg::INDEX_W-1:0]          pixel_index;
  logic [pls_pkg::COLOUR_W-1:0]         entry_colour;
  logic                                 frame_end;

  modport source (output valid, kind, pixel_index, entry_colour, frame_end, input ready);
  modport sink (input valid, kind, pixel_index, entry_colour, frame_end, output ready);
endinterface

`default_nettype wire

[rtl/pls_out_if.sv]
`default_nettype none

interface pls_out_if;
  logic                          valid;
  logic                          ready;
  logic                          bit_value;
  logic [pls_pkg::HIGH_W-1:0]    high_ticks;
  logic [pls_pkg::PERIOD_W-1:0]  low_ticks;
  logic                          pixel_last_bit;
  logic                          frame_last_bit;

  modport source (output valid, bit_value, high_ticks, low_ticks, pixel_last_bit,
                  frame_last_bit, input ready);
  modport sink (input valid, bit_value, high_ticks, low_ticks, pixel_last_bit,
                frame_last_bit, output ready);
endinterface

`default_nettype wire

[rtl/pls_cfg.sv]
`default_nettype none

module pls_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pls_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pls_pkg::DATA_W-1:0]   pwdata,
  output logic      [pls_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output pls_pkg::pls_cfg_t                 cfg
);

  pls_pkg::pls_cfg_t  regs;
  pls_pkg::reg_index_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = pls_pkg::reg_index_t'(paddr[pls_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dim_enable       <= 1'b0;
      regs.dim_shift        <= pls_pkg::RESET_DIM_SHIFT;
      regs.zero_high_ticks  <= pls_pkg::RESET_ZERO_HIGH;
      regs.one_high_ticks   <= pls_pkg::RESET_ONE_HIGH;
      regs.bit_period_ticks <= pls_pkg::RESET_PERIOD;
    end else if (wr_en) begin
      case (reg_sel)
        pls_pkg::REG_DIM_ENABLE: regs.dim_enable <= pwdata[0];
        pls_pkg::REG_DIM_SHIFT:  regs.dim_shift <= pwdata[pls_pkg::SHIFT_W-1:0];
        pls_pkg::REG_ZERO_HIGH:  regs.zero_high_ticks <= pwdata[pls_pkg::HIGH_W-1:0];
        pls_pkg::REG_ONE_HIGH:   regs.one_high_ticks <= pwdata[pls_pkg::HIGH_W-1:0];
        pls_pkg::REG_PERIOD:     regs.bit_period_ticks <= pwdata[pls_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pls_pkg::REG_DIM_ENABLE: prdata = pls_pkg::DATA_W'(regs.dim_enable);
      pls_pkg::REG_DIM_SHIFT:  prdata = pls_pkg::DATA_W'(regs.dim_shift);
      pls_pkg::REG_ZERO_HIGH:  prdata = pls_pkg::DATA_W'(regs.zero_high_ticks);
      pls_pkg::REG_ONE_HIGH:   prdata = pls_pkg::DATA_W'(regs.one_high_ticks);
      pls_pkg::REG_PERIOD:     prdata = pls_pkg::DATA_W'(regs.bit_period_ticks);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/pls_front.sv]
`default_nettype none

module pls_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pls_pkg::pls_cfg_t cfg,
  pls_in_if.sink                 pixel_in,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output pls_pkg::pls_pixel_t    push_data
);

  logic [pls_pkg::COLOUR_W-1:0] palette [pls_pkg::PALETTE_DEPTH];
  logic [pls_pkg::COLOUR_W-1:0] rdata;
  logic                         s1_valid;
  logic                         s1_dim;
  logic                         s1_frame_end;
  logic                         accept;
  logic                         is_pixel;
  pls_pkg::slot_t               slot;

  function automatic logic [7:0] dim_byte(logic [7:0] b, logic [pls_pkg::SHIFT_W-1:0] sh);
    logic [7:0] r;
    if (sh[pls_pkg::SHIFT_W-1]) begin
      r = '0;
    end else begin
      r = b >> sh[pls_pkg::SHIFT_W-2:0];
    end
    return r;
  endfunction

  assign pixel_in.ready = !s1_valid || push_ready;
  assign accept   = pixel_in.valid && pixel_in.ready;
  assign is_pixel = (pixel_in.kind == pls_pkg::KIND_PIXEL);
  assign slot     = pls_pkg::SLOT_TABLE[pixel_in.pixel_index];

  // palette: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && !is_pixel) begin
      palette[slot] <= pixel_in.entry_colour;
    end
    if (accept && is_pixel) begin
      rdata <= palette[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_pixel) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      s1_dim       <= !pixel_in.pixel_index[pls_pkg::USER_ENTRY_BIT];
      s1_frame_end <= pixel_in.frame_end;
    end
  end

  assign push_valid = s1_valid;

  always_comb begin
    push_data.frame_end = s1_frame_end;
    if (cfg.dim_enable && s1_dim) begin
      push_data.word = {dim_byte(rdata[23:16], cfg.dim_shift),
                        dim_byte(rdata[15:8], cfg.dim_shift),
                        dim_byte(rdata[7:0], cfg.dim_shift)};
    end else begin
      push_data.word = rdata;
    end
  end

endmodule

`default_nettype wire

[rtl/pls_queue.sv]
`default_nettype none

module pls_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire pls_pkg::pls_pixel_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output pls_pkg::pls_pixel_t      pop_data
);

  localparam int PTR_W = (pls_pkg::QUEUE_DEPTH > 1) ? $clog2(pls_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pls_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pls_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(pls_pkg::QUEUE_DEPTH);

  pls_pkg::pls_pixel_t entries [pls_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pls_back.sv]
`default_nettype none

module pls_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pls_pkg::pls_cfg_t   cfg,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire pls_pkg::pls_pixel_t pop_data,
  pls_out_if.source                symbol_out
);

  logic [pls_pkg::COLOUR_W-1:0]  word;
  logic [pls_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic                          cur_valid;
  logic                          cur_frame_end;
  logic                          out_valid;
  logic                          bit_value;
  logic [pls_pkg::HIGH_W-1:0]    high_ticks;
  logic [pls_pkg::PERIOD_W-1:0]  low_ticks;
  logic                          pixel_last_bit;
  logic                          frame_last_bit;
  logic                          emit;
  logic                          last;
  logic                          load;
  logic [pls_pkg::HIGH_W-1:0]    hi_raw;
  logic [pls_pkg::HIGH_W-1:0]    hi;
  logic [pls_pkg::PERIOD_W-1:0]  hi_ext;
  logic [pls_pkg::PERIOD_W-1:0]  lo;

  assign last      = (bit_cnt == pls_pkg::LAST_BIT);
  assign emit      = cur_valid && (!out_valid || symbol_out.ready);
  assign pop_ready = !cur_valid || (emit && last);
  assign load      = pop_valid && pop_ready;

  // symbol timing for the current msb
  always_comb begin
    hi_raw = word[pls_pkg::COLOUR_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    hi     = (hi_raw == '0) ? pls_pkg::HIGH_W'(1) : hi_raw;
    hi_ext = pls_pkg::PERIOD_W'(hi);
    lo     = (cfg.bit_period_ticks > hi_ext) ? (cfg.bit_period_ticks - hi_ext) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (symbol_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word          <= pop_data.word;
      bit_cnt       <= '0;
      cur_frame_end <= pop_data.frame_end;
    end else if (emit) begin
      word    <= {word[pls_pkg::COLOUR_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (emit) begin
      bit_value      <= word[pls_pkg::COLOUR_W-1];
      high_ticks     <= hi;
      low_ticks      <= lo;
      pixel_last_bit <= last;
      frame_last_bit <= last && cur_frame_end;
    end
  end

  assign symbol_out.valid          = out_valid;
  assign symbol_out.bit_value      = bit_value;
  assign symbol_out.high_ticks     = high_ticks;
  assign symbol_out.low_ticks      = low_ticks;
  assign symbol_out.pixel_last_bit = pixel_last_bit;
  assign symbol_out.frame_last_bit = frame_last_bit;

`ifndef SYNTHESIS
  a_frame_implies_pixel_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last_bit |-> pixel_last_bit)
    else $error("frame end flag without pixel end flag");

  a_high_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> high_ticks != '0)
    else $error("symbol with zero high time");

  a_pop_at_pixel_boundary: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |-> !cur_valid || (emit && last))
    else $error("queue popped in the middle of a pixel");

  a_new_pixel_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    load |=> cur_valid && bit_cnt == '0)
    else $error("pixel load did not restart bit count");
`endif

endmodule

`default_nettype wire

[rtl/palette_led_pixel_serializer.sv]
`default_nettype none

// channel     | dir | handshake     | payload
// pixel_in    | in  | valid/ready   | kind, pixel_index, entry_colour, frame_end
// symbol_out  | out | valid/ready   | bit_value, high_ticks, low_ticks, pixel/frame last
// apb         | in  | psel/penable  | paddr[4:2] selects register, pwrite, pwdata, prdata
//
// a palette write gives no output
// a pixel gives 24 symbols, one per cycle from the output shifter while symbol_out is ready,
// and the input stalls once the queue is full and a looked-up pixel waits to enter it
// first symbol after pixel accept is registered in turn: palette read, queue, load, output
// two-pixel queue between lookup and shifter absorbs output stalls
// rst is synchronous; palette contents are not cleared and read as written

module palette_led_pixel_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pls_in_if.sink                           pixel_in,
  pls_out_if.source                        symbol_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pls_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pls_pkg::DATA_W-1:0]  pwdata,
  output logic      [pls_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  pls_pkg::pls_cfg_t   cfg;
  pls_pkg::pls_pixel_t push_data;
  pls_pkg::pls_pixel_t pop_data;
  logic                push_valid;
  logic                push_ready;
  logic                pop_valid;
  logic                pop_ready;

  pls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_in   (pixel_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .symbol_out (symbol_out)
  );

endmodule

`default_nettype wire
